@@ sv/conv3x3_byte_wrap_filter_unit_assert.svh @@
// assertion macros for the 3x3 convolution filter
`ifndef CONV3X3_BYTE_WRAP_FILTER_UNIT_ASSERT_SVH
`define CONV3X3_BYTE_WRAP_FILTER_UNIT_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define CBWF_ASSERT_IMPL(label, clk_s, rst_s, ante, cons, msg) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define CBWF_ASSERT_NEXT(label, clk_s, rst_s, ante, cons, msg) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/cbwf_pkg.sv @@
// shared types and constants of the 3x3 convolution filter
package cbwf_pkg;

    localparam int MAX_WIDTH_DEF = 1024;
    localparam int KERNEL_SIZE = 3;
    localparam int TAPS = KERNEL_SIZE * KERNEL_SIZE;
    localparam int COEF_FRAC_BITS = 8;

    localparam int PIX_W = 8;
    localparam int COEF_W = 16;
    localparam int FW_W = 11;
    localparam int FH_W = 13;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 64;
    localparam int COEFS_PER_PACK = CFG_DATA_W / COEF_W;

    // line store keeps four rows, addressed by stream row modulo four
    localparam int ROW_SLOTS = 4;
    localparam int SLOT_W = $clog2(ROW_SLOTS);

    localparam logic [FW_W-1:0] FRAME_WIDTH_RST = 11'd640;
    localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = 13'd480;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_PACK_A = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_PACK_B = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_LAST = 3'd4;

    localparam int QUEUE_DEPTH = 16;
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef logic [ROW_SLOTS-1:0][PIX_W-1:0] row_word_t;

    typedef struct packed {
        logic                        valid;
        logic                        frame_end;
        logic [PIX_W-1:0]            sum;
        logic [TAPS-1:0][PIX_W-1:0]  taps;
    } tap_flow_t;

    typedef struct packed {
        logic [PIX_W-1:0] result_pixel;
        logic             frame_end;
    } result_t;

    typedef struct packed {
        logic              empty;
        logic              full;
        logic [QCNT_W-1:0] count;
    } queue_status_t;

endpackage

@@ sv/cbwf_if.sv @@
// stream and configuration channel interfaces of the 3x3 convolution filter
interface cbwf_pix_if;
    import cbwf_pkg::*;

    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel;
    logic             flush;

    modport source (output valid, output pixel, output flush, input ready);
    modport sink (input valid, input pixel, input flush, output ready);
endinterface

interface cbwf_res_if;
    import cbwf_pkg::*;

    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] result_pixel;
    logic             frame_end;

    modport source (output valid, output result_pixel, output frame_end, input ready);
    modport sink (input valid, input result_pixel, input frame_end, output ready);
endinterface

interface cbwf_cfg_if;
    import cbwf_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

@@ sv/cbwf_line_store.sv @@
// four-row line store, one byte lane per row slot, one write and two reads per cycle
module cbwf_line_store #(
    parameter int MAX_WIDTH = cbwf_pkg::MAX_WIDTH_DEF
) (
    input  logic                         clk,
    input  logic                         wr_en,
    input  logic [$clog2(MAX_WIDTH)-1:0] wr_col,
    input  logic [cbwf_pkg::SLOT_W-1:0]  wr_slot,
    input  logic [cbwf_pkg::PIX_W-1:0]   wr_pixel,
    input  logic [$clog2(MAX_WIDTH)-1:0] rd_col_a,
    input  logic [$clog2(MAX_WIDTH)-1:0] rd_col_b,
    output cbwf_pkg::row_word_t          rd_word_a,
    output cbwf_pkg::row_word_t          rd_word_b
);
    import cbwf_pkg::*;

    row_word_t mem [MAX_WIDTH];
    row_word_t rd_a_reg;
    row_word_t rd_b_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_col][wr_slot] <= wr_pixel;
        end
        rd_a_reg <= mem[rd_col_a];
        rd_b_reg <= mem[rd_col_b];
    end

    assign rd_word_a = rd_a_reg;
    assign rd_word_b = rd_b_reg;

endmodule

@@ sv/cbwf_tap_cell.sv @@
// one tap cell: multiplies its pixel by its coefficient and adds the byte term to the running sum
module cbwf_tap_cell (
    input  logic                               clk,
    input  logic                               rst_n,
    input  cbwf_pkg::tap_flow_t                flow_in,
    input  logic signed [cbwf_pkg::COEF_W-1:0] coef,
    output cbwf_pkg::tap_flow_t                flow_out
);
    import cbwf_pkg::*;

    localparam int PROD_W = PIX_W + COEF_W + 1;
    localparam logic [PROD_W-1:0] ROUND_ADJ = PROD_W'((1 << COEF_FRAC_BITS) - 1);

    logic signed [PROD_W-1:0] prod;
    logic [PROD_W-1:0]        adj;
    logic [PIX_W-1:0]         term;
    tap_flow_t                flow_next;
    tap_flow_t                flow_reg;

    always_comb
    begin
        prod = $signed({1'b0, flow_in.taps[0]}) * coef;
        // negative products get a bias so the shift truncates toward zero
        adj = $unsigned(prod) + (prod[PROD_W-1] ? ROUND_ADJ : '0);
        term = adj[COEF_FRAC_BITS +: PIX_W];

        flow_next.valid = flow_in.valid;
        flow_next.frame_end = flow_in.frame_end;
        flow_next.sum = flow_in.sum + term;
        // hand the remaining taps to the next cell
        flow_next.taps = {PIX_W'(0), flow_in.taps[TAPS-1:1]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flow_reg <= '0;
        end
        else
        begin
            flow_reg <= flow_next;
        end
    end

    assign flow_out = flow_reg;

endmodule

@@ sv/cbwf_out_queue.sv @@
// result queue between the tap chain and the output channel
module cbwf_out_queue (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  cbwf_pkg::result_t       push_data,
    input  logic                    pop,
    output cbwf_pkg::result_t       head,
    output cbwf_pkg::queue_status_t status
);
    import cbwf_pkg::*;

    result_t           slots_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next = count_reg + QCNT_W'(push) - QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign head = slots_reg[rd_ptr_reg];
    assign status.empty = (count_reg == '0);
    assign status.full = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign status.count = count_reg;

endmodule

@@ sv/conv3x3_byte_wrap_filter_unit.sv @@
// top level of the 3x3 convolution filter: stream control, line store, chain of nine tap cells
// pipeline order: descriptor d1, d2 with line store read, nine tap cells, result queue
// throughput: one input item per cycle while under 16 results are pending (16-entry queue)
// reset: asynchronous active low; counters and pipeline cleared, geometry 640x480, coefs zero
// the line store is not cleared, so there is no start-up pass after reset
`include "conv3x3_byte_wrap_filter_unit_assert.svh"

module conv3x3_byte_wrap_filter_unit #(
    parameter int MAX_WIDTH = cbwf_pkg::MAX_WIDTH_DEF
) (
    input logic        clk,
    input logic        rst_n,
    cbwf_pix_if.sink   pix,
    cbwf_res_if.source res,
    cbwf_cfg_if.sink   cfg
);
    import cbwf_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int CMP_W = (WW > FW_W) ? WW : FW_W;
    localparam int LAG_W = WW + FH_W;

    typedef struct packed {
        logic              valid;
        logic [CW-1:0]     col;
        logic [SLOT_W-1:0] slot;
        logic              top_ok;
        logic              bot_ok;
        logic              left_ok;
        logic              right_ok;
        logic              frame_end;
    } desc_t;

    // configuration registers
    logic [FW_W-1:0]          fw_reg;
    logic [FH_W-1:0]          fh_reg;
    logic [CFG_DATA_W-1:0]    coef_a_reg;
    logic [CFG_DATA_W-1:0]    coef_b_reg;
    logic signed [COEF_W-1:0] coef_last_reg;
    logic                     cfg_fire;
    logic                     restart;

    // effective geometry
    logic [CMP_W-1:0] fw_ext;
    logic [WW-1:0]    eff_w;
    logic [FH_W-1:0]  eff_h;
    logic [CW-1:0]    w_last;
    logic [FH_W-1:0]  h_last;
    logic [WW:0]      thresh;

    // stream position state
    logic [CW-1:0]     in_col_reg, in_col_next;
    logic [FH_W-1:0]   in_row_reg, in_row_next;
    logic [SLOT_W-1:0] in_slot_reg, in_slot_next;
    logic [CW-1:0]     out_col_reg, out_col_next;
    logic [FH_W-1:0]   out_row_reg, out_row_next;
    logic [SLOT_W-1:0] out_slot_reg, out_slot_next;
    logic              behind_reg, behind_next;
    logic [LAG_W-1:0]  lag_reg, lag_next;

    logic acc_fire;
    logic has_px;
    logic in_col_end;
    logic in_row_end;
    logic complete;
    logic lag_ok;
    logic issue;
    logic out_col_end;
    logic out_row_end;
    logic out_wrap;

    desc_t d1_next;
    desc_t d1_reg;
    desc_t d2_reg;

    row_word_t mid_word;
    row_word_t right_word;
    row_word_t left_word_reg;
    row_word_t col_word [KERNEL_SIZE];
    logic [SLOT_W-1:0] lane [KERNEL_SIZE];
    logic [KERNEL_SIZE-1:0] row_ok;
    logic [KERNEL_SIZE-1:0] col_ok;
    logic [TAPS-1:0][PIX_W-1:0] win;

    tap_flow_t chain [TAPS+1];
    logic signed [COEF_W-1:0] coef_w [TAPS];

    result_t       q_push_data;
    result_t       q_head;
    queue_status_t q_status;
    logic          pop;
    logic [QCNT_W-1:0] pend_reg, pend_next;

    // configuration port
    assign cfg.ready = 1'b1;
    assign cfg_fire = cfg.valid & cfg.ready;
    assign restart = cfg_fire &
                     ((cfg.index == REG_FRAME_WIDTH) || (cfg.index == REG_FRAME_HEIGHT));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fw_reg <= FRAME_WIDTH_RST;
            fh_reg <= FRAME_HEIGHT_RST;
            coef_a_reg <= '0;
            coef_b_reg <= '0;
            coef_last_reg <= '0;
        end
        else if (cfg_fire)
        begin
            case (cfg.index)
                REG_FRAME_WIDTH:  fw_reg <= cfg.data[FW_W-1:0];
                REG_FRAME_HEIGHT: fh_reg <= cfg.data[FH_W-1:0];
                REG_COEF_PACK_A:  coef_a_reg <= cfg.data;
                REG_COEF_PACK_B:  coef_b_reg <= cfg.data;
                REG_COEF_LAST:    coef_last_reg <= cfg.data[COEF_W-1:0];
                default:          ;
            endcase
        end
    end

    // zero geometry counts as one, width is capped at the line store depth
    assign fw_ext = CMP_W'(fw_reg);

    always_comb
    begin
        if (fw_reg == '0)
        begin
            eff_w = WW'(1);
        end
        else if (fw_ext > CMP_W'(MAX_WIDTH))
        begin
            eff_w = WW'(MAX_WIDTH);
        end
        else
        begin
            eff_w = WW'(fw_reg);
        end
    end

    assign eff_h = (fh_reg == '0) ? FH_W'(1) : fh_reg;
    assign w_last = CW'(eff_w - WW'(1));
    assign h_last = eff_h - FH_W'(1);

    // stream control
    assign acc_fire = pix.valid & pix.ready;
    assign has_px = ~pix.flush;
    assign in_col_end = (in_col_reg == w_last);
    assign in_row_end = (in_row_reg == h_last);
    assign complete = acc_fire & has_px & in_col_end & in_row_end;

    // lag counts pixels written ahead of the next result; a result needs one row plus one
    assign thresh = has_px ? (WW+1)'(eff_w) : (WW+1)'(eff_w) + (WW+1)'(1);
    assign lag_ok = lag_reg > LAG_W'(thresh);
    assign issue = acc_fire & (behind_reg | complete | lag_ok);

    assign out_col_end = (out_col_reg == w_last);
    assign out_row_end = (out_row_reg == h_last);
    assign out_wrap = out_col_end & out_row_end;

    always_comb
    begin
        in_col_next = in_col_reg;
        in_row_next = in_row_reg;
        in_slot_next = in_slot_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        out_slot_next = out_slot_reg;
        behind_next = behind_reg;
        lag_next = lag_reg;

        if (acc_fire & has_px)
        begin
            in_col_next = in_col_end ? '0 : in_col_reg + CW'(1);
            if (in_col_end)
            begin
                in_row_next = in_row_end ? '0 : in_row_reg + FH_W'(1);
                in_slot_next = in_slot_reg + SLOT_W'(1);
            end
        end

        if (issue)
        begin
            out_col_next = out_col_end ? '0 : out_col_reg + CW'(1);
            if (out_col_end)
            begin
                out_row_next = out_row_end ? '0 : out_row_reg + FH_W'(1);
                out_slot_next = out_slot_reg + SLOT_W'(1);
            end
        end

        if (complete)
        begin
            if (behind_reg & ~out_wrap)
            begin
                // frame overrun: drop the older frame and start on the one just completed
                out_col_next = '0;
                out_row_next = '0;
                out_slot_next = in_slot_next - eff_h[SLOT_W-1:0];
                behind_next = 1'b1;
            end
            else if (behind_reg)
            begin
                behind_next = 1'b1;
            end
            else
            begin
                behind_next = ~out_wrap;
            end
        end
        else if (behind_reg & issue & out_wrap)
        begin
            behind_next = 1'b0;
        end

        if (acc_fire)
        begin
            if (complete)
            begin
                lag_next = '0;
            end
            else
            begin
                lag_next = lag_reg + LAG_W'(has_px) - LAG_W'(issue & ~behind_reg);
            end
        end

        if (restart)
        begin
            in_col_next = '0;
            in_row_next = '0;
            in_slot_next = '0;
            out_col_next = '0;
            out_row_next = '0;
            out_slot_next = '0;
            behind_next = 1'b0;
            lag_next = '0;
        end
    end

    always_comb
    begin
        d1_next.valid = issue;
        d1_next.col = out_col_reg;
        d1_next.slot = out_slot_reg;
        d1_next.top_ok = (out_row_reg != '0);
        d1_next.bot_ok = ~out_row_end;
        d1_next.left_ok = (out_col_reg != '0);
        d1_next.right_ok = ~out_col_end;
        d1_next.frame_end = out_wrap;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_col_reg <= '0;
            in_row_reg <= '0;
            in_slot_reg <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
            out_slot_reg <= '0;
            behind_reg <= 1'b0;
            lag_reg <= '0;
            d1_reg <= '0;
            d2_reg <= '0;
            pend_reg <= '0;
        end
        else
        begin
            in_col_reg <= in_col_next;
            in_row_reg <= in_row_next;
            in_slot_reg <= in_slot_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
            out_slot_reg <= out_slot_next;
            behind_reg <= behind_next;
            lag_reg <= lag_next;
            d1_reg <= d1_next;
            d2_reg <= d1_reg;
            pend_reg <= pend_next;
        end
    end

    // line store: written at transfer, read in the next cycle so the new pixel is seen
    cbwf_line_store #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_line_store (
        .clk       (clk),
        .wr_en     (acc_fire & has_px),
        .wr_col    (in_col_reg),
        .wr_slot   (in_slot_reg),
        .wr_pixel  (pix.pixel),
        .rd_col_a  (d1_reg.col),
        .rd_col_b  (d1_reg.col + CW'(1)),
        .rd_word_a (mid_word),
        .rd_word_b (right_word)
    );

    // left column is the previous result's center column
    always_ff @(posedge clk)
    begin
        if (d2_reg.valid)
        begin
            left_word_reg <= mid_word;
        end
    end

    always_comb
    begin
        col_word[0] = left_word_reg;
        col_word[1] = mid_word;
        col_word[2] = right_word;
        lane[0] = d2_reg.slot - SLOT_W'(1);
        lane[1] = d2_reg.slot;
        lane[2] = d2_reg.slot + SLOT_W'(1);
        row_ok = {d2_reg.bot_ok, 1'b1, d2_reg.top_ok};
        col_ok = {d2_reg.right_ok, 1'b1, d2_reg.left_ok};
        for (int r = 0; r < KERNEL_SIZE; r++)
        begin
            for (int c = 0; c < KERNEL_SIZE; c++)
            begin
                win[r*KERNEL_SIZE + c] = (row_ok[r] & col_ok[c]) ? col_word[c][lane[r]] : '0;
            end
        end

        chain[0].valid = d2_reg.valid;
        chain[0].frame_end = d2_reg.frame_end;
        chain[0].sum = '0;
        chain[0].taps = win;
    end

    // tap chain
    for (genvar k = 0; k < TAPS; k++)
    begin : g_tap
        if (k < COEFS_PER_PACK)
        begin : g_coef_a
            assign coef_w[k] = coef_a_reg[COEF_W*k +: COEF_W];
        end
        else if (k < 2 * COEFS_PER_PACK)
        begin : g_coef_b
            assign coef_w[k] = coef_b_reg[COEF_W*(k-COEFS_PER_PACK) +: COEF_W];
        end
        else
        begin : g_coef_last
            assign coef_w[k] = coef_last_reg;
        end

        cbwf_tap_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .flow_in  (chain[k]),
            .coef     (coef_w[k]),
            .flow_out (chain[k+1])
        );
    end

    // result queue and output channel
    assign q_push_data.result_pixel = chain[TAPS].sum;
    assign q_push_data.frame_end = chain[TAPS].frame_end;
    assign pop = res.valid & res.ready;

    cbwf_out_queue u_out_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (chain[TAPS].valid),
        .push_data (q_push_data),
        .pop       (pop),
        .head      (q_head),
        .status    (q_status)
    );

    assign res.valid = ~q_status.empty;
    assign res.result_pixel = q_head.result_pixel;
    assign res.frame_end = q_head.frame_end;

    // results issued and not yet transferred reserve queue room
    assign pend_next = pend_reg + QCNT_W'(issue) - QCNT_W'(pop);
    assign pix.ready = (pend_reg < QCNT_W'(QUEUE_DEPTH));

    `CBWF_ASSERT_IMPL(a_queue_no_overflow, clk, rst_n, chain[TAPS].valid, !q_status.full, "result queue written while full")
    `CBWF_ASSERT_IMPL(a_queue_within_pending, clk, rst_n, 1'b1, q_status.count <= pend_reg, "queue holds more than outstanding results")
    `CBWF_ASSERT_NEXT(a_behind_issues, clk, rst_n, acc_fire && behind_reg, d1_reg.valid, "draining transfer gave no result")

endmodule

@@ tb/conv3x3_byte_wrap_filter_unit_tb.sv @@
// self-checking testbench for the 3x3 convolution filter with random stimulus and flow control
module conv3x3_byte_wrap_filter_unit_tb;
    import cbwf_pkg::*;

    localparam int DRAIN_CYCLES = 24;
    localparam int IDLE_GUARD = 40000;

    typedef struct {
        logic [PIX_W-1:0] pixel;
        logic             flush;
    } pix_item_t;

    logic clk = 1'b0;
    logic rst_n;

    cbwf_pix_if pix ();
    cbwf_res_if res ();
    cbwf_cfg_if cfg ();

    conv3x3_byte_wrap_filter_unit uut (
        .clk   (clk),
        .rst_n (rst_n),
        .pix   (pix),
        .res   (res),
        .cfg   (cfg)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    pix_item_t pending_pixels[$];
    result_t   conv_results_due[$];

    int unsigned src_idle_pct = 0;
    int unsigned snk_stall_pct = 0;
    int unsigned errors = 0;
    int unsigned pixels_in = 0;
    int unsigned flushes_in = 0;
    int unsigned results_checked = 0;
    int unsigned frame_ends_seen = 0;
    int unsigned settings_used = 0;

    logic [15:0] coef_extremes [8] = '{16'h8000, 16'h7FFF, 16'hFFFF, 16'h0000,
                                       16'h0100, 16'hFF00, 16'h0001, 16'h0080};

    // predictor state: registers, stream positions and four-row pixel store
    logic [PIX_W-1:0]      row_mem [ROW_SLOTS][MAX_WIDTH_DEF];
    logic [FW_W-1:0]       geo_width = FRAME_WIDTH_RST;
    logic [FH_W-1:0]       geo_height = FRAME_HEIGHT_RST;
    logic [CFG_DATA_W-1:0] coef_a = '0;
    logic [CFG_DATA_W-1:0] coef_b = '0;
    logic [COEF_W-1:0]     coef_c = '0;
    int unsigned in_row = 0, in_col = 0, out_row = 0, out_col = 0;
    int unsigned in_slot = 0, out_slot = 0;
    bit          trailing = 1'b0;

    initial
    begin
        for (int s = 0; s < ROW_SLOTS; s++)
            for (int c = 0; c < MAX_WIDTH_DEF; c++)
                row_mem[s][c] = '0;
    end

    function automatic int unsigned active_width();
        if (geo_width == 0)
            return 1;
        if (geo_width > MAX_WIDTH_DEF)
            return MAX_WIDTH_DEF;
        return geo_width;
    endfunction

    function automatic int unsigned active_height();
        return (geo_height == 0) ? 1 : geo_height;
    endfunction

    function automatic void restart_positions();
        in_row = 0;
        in_col = 0;
        out_row = 0;
        out_col = 0;
        in_slot = 0;
        out_slot = 0;
        trailing = 1'b0;
    endfunction

    function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] val);
        case (idx)
            REG_FRAME_WIDTH:
            begin
                geo_width = val[FW_W-1:0];
                restart_positions();
            end
            REG_FRAME_HEIGHT:
            begin
                geo_height = val[FH_W-1:0];
                restart_positions();
            end
            REG_COEF_PACK_A: coef_a = val;
            REG_COEF_PACK_B: coef_b = val;
            REG_COEF_LAST:   coef_c = val[COEF_W-1:0];
            default: ;
        endcase
    endfunction

    function automatic logic signed [COEF_W-1:0] coef_word(input int k);
        if (k < COEFS_PER_PACK)
            return coef_a[COEF_W*k +: COEF_W];
        if (k < 2 * COEFS_PER_PACK)
            return coef_b[COEF_W*(k-COEFS_PER_PACK) +: COEF_W];
        return coef_c;
    endfunction

    // each tap product truncated toward zero, low byte kept, bytes summed mod 256
    function automatic logic [PIX_W-1:0] window_sum(input int unsigned w, input int unsigned h);
        logic [PIX_W-1:0] acc;
        logic [PIX_W-1:0] px;
        int r, c, prod, mag;
        acc = '0;
        for (int k = 0; k < TAPS; k++)
        begin
            r = int'(out_row) + k / KERNEL_SIZE - 1;
            c = int'(out_col) + k % KERNEL_SIZE - 1;
            if (r < 0 || r >= int'(h) || c < 0 || c >= int'(w))
                px = '0;
            else
                px = row_mem[(out_slot + k / KERNEL_SIZE + 3) & 3][c];
            prod = int'(px) * int'(coef_word(k));
            mag = (prod < 0) ? -prod : prod;
            mag = mag >> COEF_FRAC_BITS;
            if (prod < 0)
                mag = -mag;
            acc += mag[PIX_W-1:0];
        end
        return acc;
    endfunction

    function automatic void advance_filter(input logic [PIX_W-1:0] pixel_in,
                                           input logic flush_in,
                                           output bit produced, output result_t outcome);
        int unsigned w, h;
        bit was_trailing, complete, ready, wrapped;
        longint unsigned written, need, last_pos;
        w = active_width();
        h = active_height();
        was_trailing = trailing;
        complete = 1'b0;
        wrapped = 1'b0;
        produced = 1'b0;
        outcome = '0;

        if (!flush_in)
        begin
            row_mem[in_slot & 3][in_col] = pixel_in;
            in_col++;
            if (in_col >= w)
            begin
                in_col = 0;
                in_row++;
                in_slot++;
                if (in_row >= h)
                begin
                    in_row = 0;
                    complete = 1'b1;
                end
            end
        end

        if (was_trailing || complete)
            ready = 1'b1;
        else
        begin
            written = in_row;
            written = written * w + in_col;
            need = out_row;
            need = need * w + out_col + w + 1;
            last_pos = w;
            last_pos = last_pos * h - 1;
            if (need > last_pos)
                need = last_pos;
            ready = written > need;
        end

        if (ready)
        begin
            outcome.result_pixel = window_sum(w, h);
            outcome.frame_end = (out_row + 1 >= h) && (out_col + 1 >= w);
            out_col++;
            if (out_col >= w)
            begin
                out_col = 0;
                out_row++;
                out_slot++;
                if (out_row >= h)
                begin
                    out_row = 0;
                    wrapped = 1'b1;
                end
            end
            produced = 1'b1;
        end

        // a completed frame leaves its tail of results to be drained later
        if (complete)
        begin
            if (was_trailing && !wrapped)
            begin
                out_row = 0;
                out_col = 0;
                out_slot = in_slot - h;
                trailing = 1'b1;
            end
            else if (was_trailing)
                trailing = 1'b1;
            else
                trailing = !wrapped;
        end
        else if (was_trailing && wrapped)
            trailing = 1'b0;
    endfunction

    // pixel stream driver
    always @(posedge clk or negedge rst_n)
    begin : pixel_driver
        pix_item_t nxt;
        result_t   due;
        bit        got;
        if (!rst_n)
        begin
            pix.valid <= 1'b0;
            pix.pixel <= '0;
            pix.flush <= 1'b0;
        end
        else
        begin
            if (pix.valid && pix.ready)
            begin
                advance_filter(pix.pixel, pix.flush, got, due);
                if (got)
                    conv_results_due.push_back(due);
                if (pix.flush)
                    flushes_in++;
                else
                    pixels_in++;
            end
            if (!pix.valid || pix.ready)
            begin
                if (pending_pixels.size() != 0 && $urandom_range(99) >= src_idle_pct)
                begin
                    nxt = pending_pixels.pop_front();
                    pix.valid <= 1'b1;
                    pix.pixel <= nxt.pixel;
                    pix.flush <= nxt.flush;
                end
                else
                    pix.valid <= 1'b0;
            end
        end
    end

    // result monitor and backpressure
    always @(posedge clk or negedge rst_n)
    begin : result_monitor
        result_t want;
        if (!rst_n)
            res.ready <= 1'b0;
        else
        begin
            if (res.valid && res.ready)
            begin
                if (conv_results_due.size() == 0)
                begin
                    $display("%0t: unexpected result pixel %0d frame_end %0b",
                             $time, res.result_pixel, res.frame_end);
                    errors++;
                end
                else
                begin
                    want = conv_results_due.pop_front();
                    if (res.result_pixel !== want.result_pixel)
                    begin
                        $display("%0t: result_pixel expected %0d actual %0d",
                                 $time, want.result_pixel, res.result_pixel);
                        errors++;
                    end
                    if (res.frame_end !== want.frame_end)
                    begin
                        $display("%0t: frame_end expected %0b actual %0b",
                                 $time, want.frame_end, res.frame_end);
                        errors++;
                    end
                    if (want.frame_end)
                        frame_ends_seen++;
                    results_checked++;
                end
            end
            res.ready <= ($urandom_range(99) >= snk_stall_pct);
        end
    end

    task automatic set_idle(input int unsigned mode);
        case (mode % 4)
            0:
            begin
                src_idle_pct = 0;
                snk_stall_pct = 0;
            end
            1:
            begin
                src_idle_pct = 46;
                snk_stall_pct = 0;
            end
            2:
            begin
                src_idle_pct = 0;
                snk_stall_pct = 46;
            end
            default:
            begin
                src_idle_pct = 32;
                snk_stall_pct = 32;
            end
        endcase
    endtask

    // leaves valid high; the caller lowers it after the last transfer
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data <= val;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        apply_reg(idx, val);
    endtask

    task automatic configure(input logic [FW_W-1:0] w, input logic [FH_W-1:0] h,
                             input logic [CFG_DATA_W-1:0] pa, input logic [CFG_DATA_W-1:0] pb,
                             input logic [COEF_W-1:0] pl, input bit all_spares);
        logic [CFG_DATA_W-1:0] junk;
        junk = {$urandom, $urandom};
        if ($urandom_range(1))
            junk = '0;
        cfg_write(REG_FRAME_WIDTH, {junk[CFG_DATA_W-1:FW_W], w});
        cfg_write(REG_FRAME_HEIGHT, {junk[CFG_DATA_W-1:FH_W], h});
        cfg_write(REG_COEF_PACK_A, pa);
        cfg_write(REG_COEF_PACK_B, pb);
        cfg_write(REG_COEF_LAST, {junk[CFG_DATA_W-1:COEF_W], pl});
        // unmapped indexes must leave everything alone
        if (all_spares)
            for (int k = 1; k <= 3; k++)
                cfg_write(REG_COEF_LAST + CFG_IDX_W'(k), {$urandom, $urandom});
        else if ($urandom_range(3) == 0)
            cfg_write(REG_COEF_LAST + CFG_IDX_W'($urandom_range(1, 3)), {$urandom, $urandom});
        cfg.valid <= 1'b0;
        settings_used++;
    endtask

    task automatic wait_idle();
        int guard;
        guard = 0;
        while ((pending_pixels.size() != 0 || pix.valid || conv_results_due.size() != 0)
               && guard < IDLE_GUARD)
        begin
            @(posedge clk);
            guard++;
        end
        if (conv_results_due.size() != 0)
        begin
            $display("%0t: %0d results expected, none arrived (expected %0d actual 0)",
                     $time, conv_results_due.size(), conv_results_due[0].result_pixel);
            errors++;
            conv_results_due.delete();
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic logic [PIX_W-1:0] rand_pixel();
        int unsigned sel;
        sel = $urandom_range(9);
        if (sel == 0)
            return '0;
        if (sel == 1)
            return '1;
        return PIX_W'($urandom);
    endfunction

    function automatic logic [COEF_W-1:0] pick_coef();
        if ($urandom_range(1))
            return coef_extremes[$urandom_range(7)];
        return COEF_W'($urandom);
    endfunction

    task automatic queue_item(input logic [PIX_W-1:0] p, input logic fl);
        pix_item_t it;
        it.pixel = p;
        it.flush = fl;
        pending_pixels.push_back(it);
    endtask

    task automatic queue_frame(input int unsigned n, input int unsigned flush_pct);
        for (int unsigned i = 0; i < n; i++)
        begin
            if ($urandom_range(99) < flush_pct)
                queue_item(PIX_W'($urandom), 1'b1);
            queue_item(rand_pixel(), 1'b0);
        end
    endtask

    task automatic queue_drain(input int unsigned n);
        for (int unsigned i = 0; i < n; i++)
            queue_item(PIX_W'($urandom), 1'b1);
    endtask

    initial
    begin : stimulus
        int unsigned w, h, frames, sel, rand_pixels, phase, n;
        logic [CFG_DATA_W-1:0] pa, pb;
        logic [COEF_W-1:0] pl;

        pix.valid = 1'b0;
        pix.pixel = '0;
        pix.flush = 1'b0;
        res.ready = 1'b0;
        cfg.valid = 1'b0;
        cfg.index = '0;
        cfg.data = '0;
        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset geometry is 640 wide: a few pixels, nothing can be ready
        set_idle(0);
        queue_item(8'h00, 1'b0);
        queue_item(8'hFF, 1'b0);
        queue_item(8'h33, 1'b1);
        queue_item(8'h5A, 1'b0);
        wait_idle();

        // zero geometry behaves as a single-pixel frame
        configure('0, '0, {16'h0100, 16'hFFFF, 16'h7FFF, 16'h8000},
                  {16'h0080, 16'h0001, 16'hFF00, 16'h0100}, 16'h8001, 1'b1);
        queue_item(8'hFF, 1'b0);
        queue_item(8'h00, 1'b0);
        queue_item(8'hC3, 1'b1);
        wait_idle();

        // 3x2 frames with extreme taps, flush with nothing ready, next frame before drain
        set_idle(3);
        configure(3, 2, {16'h8000, 16'h7FFF, 16'hFFFF, 16'h0100},
                  {16'hFF00, 16'h0080, 16'hFF7F, 16'h0001}, 16'h8000, 1'b0);
        queue_item(8'hA5, 1'b1);
        queue_item(8'h00, 1'b0);
        queue_item(8'hFF, 1'b0);
        queue_item(8'h55, 1'b0);
        queue_item(8'hAA, 1'b0);
        queue_item(8'h80, 1'b0);
        queue_item(8'h7F, 1'b0);
        queue_item(8'hFF, 1'b0);
        queue_item(8'h01, 1'b0);
        queue_item(8'hFE, 1'b0);
        queue_item(8'h10, 1'b0);
        queue_item(8'hC3, 1'b0);
        queue_item(8'h3C, 1'b0);
        queue_drain(5);
        wait_idle();

        // width register beyond the line store clamps to its size
        set_idle(1);
        configure(11'h7FF, 2, {$urandom, $urandom}, {$urandom, $urandom}, pick_coef(), 1'b0);
        queue_frame(MAX_WIDTH_DEF + 6, 0);
        wait_idle();

        // tall single-column frame, cut short by the next geometry write
        set_idle(2);
        configure(1, 4096, {$urandom, $urandom}, {$urandom, $urandom}, pick_coef(), 1'b0);
        queue_frame(150, 5);
        wait_idle();

        set_idle(3);
        configure(2, 13'h1FFF, {$urandom, $urandom}, {$urandom, $urandom}, pick_coef(), 1'b0);
        queue_frame(40, 5);
        wait_idle();

        // random geometries, coefficients and frame sequences
        rand_pixels = 0;
        phase = 0;
        while (rand_pixels < 850)
        begin
            set_idle(phase);
            sel = $urandom_range(9);
            if (sel < 7)
                w = $urandom_range(1, 6);
            else if (sel < 9)
                w = $urandom_range(7, 24);
            else
                w = $urandom_range(25, 80);
            h = (w <= 6) ? $urandom_range(1, 8) : $urandom_range(1, 4);
            if ($urandom_range(3) == 0)
            begin
                pa = {$urandom, $urandom};
                pb = {$urandom, $urandom};
            end
            else
            begin
                pa = {pick_coef(), pick_coef(), pick_coef(), pick_coef()};
                pb = {pick_coef(), pick_coef(), pick_coef(), pick_coef()};
            end
            pl = pick_coef();
            configure(w, h, pa, pb, pl, 1'b0);
            frames = (w > 24) ? 1 : $urandom_range(1, 3);
            for (int unsigned f = 0; f < frames; f++)
            begin
                if (f == frames - 1 && w * h > 1 && $urandom_range(4) == 0)
                begin
                    // broken sequence: frame left unfinished
                    n = $urandom_range(1, w * h - 1);
                    queue_frame(n, 10);
                end
                else
                begin
                    n = w * h;
                    queue_frame(n, 10);
                    if (f == frames - 1 || $urandom_range(2) != 0)
                        queue_drain(w + 2);
                end
                rand_pixels += n;
            end
            wait_idle();
            phase++;
        end

        wait_idle();
        $display("covered %0d pixel and %0d flush transfers over %0d register settings",
                 pixels_in, flushes_in, settings_used);
        $display("checked %0d result pixels including %0d frame ends",
                 results_checked, frame_ends_seen);
        if (errors == 0)
            $display("conv3x3_byte_wrap_filter_unit_tb passed");
        else
            $display("conv3x3_byte_wrap_filter_unit_tb failed");
        $finish;
    end

    initial
    begin
        #4000000;
        $display("%0t: timeout", $time);
        $display("conv3x3_byte_wrap_filter_unit_tb failed");
        $finish;
    end

endmodule
